// ===== hw/rtl/basic_block_vector_profiler_defines.svh =====
// Assertion macros shared by the profiler RTL.
`ifndef BASIC_BLOCK_VECTOR_PROFILER_DEFINES_SVH
`define BASIC_BLOCK_VECTOR_PROFILER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define BBVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define BBVP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define BBVP_ASSERT(lbl, prop, msg)
`define BBVP_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== hw/rtl/bbvp_pkg.sv =====
// Types and constants of the basic block vector profiler.
package bbvp_pkg;

  localparam int unsigned VECTOR_LEN_DEF = 16;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned PERIOD_W  = 40;
  localparam int unsigned OUT_IDX_W = 5;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned LCG_W     = 48;
  localparam int unsigned HALF_W    = 24;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned MUL_A_W   = 24;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned LANES     = 4;

  // The LCG multiplier 0x5DEECE66D split at bit 24.
  localparam logic [HALF_W-1:0] LCG_MUL_LO = 24'hECE66D;
  localparam logic [10:0]       LCG_MUL_HI = 11'h5DE;
  localparam logic [LCG_W-1:0]  LCG_ADD    = 48'hB;
  localparam logic [15:0]       SEED_LOW   = 16'h330E;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd100000000;

  localparam logic KIND_COUNTER = 1'b0;
  localparam logic KIND_TOTAL   = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [OUT_IDX_W-1:0] out_idx_t;
  typedef logic [PERIOD_W-1:0] period_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_MUL,
    ST_DUMP,
    ST_TOTAL
  } bbvp_state_e;

  // Micro-steps of one counter update on the shared multiplier.
  typedef enum logic [2:0] {
    MS_LO_LO,
    MS_LO_HI,
    MS_HI_LO,
    MS_FOLD,
    MS_LEN_LO,
    MS_LEN_HI,
    MS_ACC_HI
  } bbvp_mstep_e;

endpackage

// ===== hw/rtl/bbvp_in_if.sv =====
// Instruction channel: valid, ready and one retired instruction.
interface bbvp_in_if;
  import bbvp_pkg::*;

  logic  valid;
  logic  ready;
  addr_t fetch_address;
  size_t instr_size;
  logic  ends_block;

  modport source (output valid, output fetch_address, output instr_size,
                  output ends_block, input ready);
  modport sink (input valid, input fetch_address, input instr_size,
                input ends_block, output ready);
endinterface

// ===== hw/rtl/bbvp_out_if.sv =====
// Dump channel: valid, ready and one vector entry or total.
interface bbvp_out_if;
  import bbvp_pkg::*;

  logic     valid;
  logic     ready;
  logic     item_kind;
  out_idx_t entry_index;
  value_t   entry_value;
  logic     last_of_dump;

  modport source (output valid, output item_kind, output entry_index,
                  output entry_value, output last_of_dump, input ready);
  modport sink (input valid, input item_kind, input entry_index,
                input entry_value, input last_of_dump, output ready);
endinterface

// ===== hw/rtl/basic_block_vector_profiler.sv =====
// Basic block vector profiler with random projection onto 64-bit counters.
// Inside a basic block an instruction word is taken every cycle unless the block is busy.
// A closed non-empty block first runs the shared 24x32 multiplier for seven micro-steps
// per counter. A dump sends VECTOR_LEN + 1 words (none at a zero total), one per cycle
// while the sink is ready; a period write recomputes the count phase bit-serially. Reset
// clears all control state and the counters, loads period 100000000 and leaves it ready.
`include "basic_block_vector_profiler_defines.svh"

module basic_block_vector_profiler #(
  parameter int unsigned VECTOR_LEN = bbvp_pkg::VECTOR_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bbvp_in_if.sink                       instr_i,
  bbvp_out_if.source                    dump_o,
  input  logic                          cfg_we_i,
  input  logic [bbvp_pkg::PERIOD_W-1:0] cfg_wdata_i
);
  import bbvp_pkg::*;

  localparam int unsigned IDX_W = $clog2(VECTOR_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VECTOR_LEN - 1);

  // Control state.
  bbvp_state_e state_q, state_d;
  bbvp_mstep_e mstep_q, mstep_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [5:0] bit_q, bit_d;
  logic rem_req_q, rem_req_d;
  logic dump_q, dump_d;

  // Architectural state of the profiler.
  period_t period_q, period_d;
  period_t phase_q, phase_d;
  value_t  sum_q, sum_d;
  value_t  total_q, total_d;
  addr_t   base_q, base_d;
  value_t  len_q, len_d;
  addr_t   exp_q, exp_d;
  logic    closed_q, closed_d;
  value_t  cnt_q [VECTOR_LEN];
  value_t  cnt_d [VECTOR_LEN];

  // Working registers of the sequencer.
  period_t rem_q, rem_d;
  value_t  plen_q, plen_d;
  logic [LCG_W-1:0] lane_q [LANES];
  logic [LCG_W-1:0] lane_d [LANES];
  logic [LCG_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  // Output register.
  logic     ov_q, ov_d;
  logic     okind_q, okind_d;
  out_idx_t oidx_q, oidx_d;
  value_t   oval_q, oval_d;
  logic     olast_q, olast_d;

  logic in_acc;
  logic out_free;
  logic brk;
  logic dump_now;
  value_t sum_inc;
  logic [PERIOD_W:0] phase_inc;
  period_t phase_next;
  logic [PERIOD_W:0] rem_shift;
  period_t rem_next;
  logic [1:0] lane_sel;
  logic [LCG_W-1:0] lane_x;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  value_t cnt_rd;

  // The block only takes an instruction word once any period change has been
  // folded into the phase.
  assign instr_i.ready = (state_q == ST_IDLE) && !rem_req_q;
  assign in_acc        = instr_i.valid && instr_i.ready;
  assign out_free      = !ov_q || dump_o.ready;

  assign dump_o.valid        = ov_q;
  assign dump_o.item_kind    = okind_q;
  assign dump_o.entry_index  = oidx_q;
  assign dump_o.entry_value  = oval_q;
  assign dump_o.last_of_dump = olast_q;

  // A block closes after a branch or when the address breaks the sequence.
  assign brk = closed_q || (exp_q != instr_i.fetch_address);

  // The total plus the open block length rises by exactly one per word, so
  // its remainder modulo the period is tracked incrementally. When the sum
  // wraps at 2^64 it is zero, and so is its remainder.
  assign sum_inc    = sum_q + 64'd1;
  assign phase_inc  = {1'b0, phase_q} + 41'd1;
  assign phase_next = ((sum_inc == '0) || (phase_inc == {1'b0, period_q})) ?
                      '0 : phase_inc[PERIOD_W-1:0];
  assign dump_now   = (period_q != '0) && (phase_next == '0);

  // One restoring step of the remainder of the sum by the period.
  assign rem_shift = {rem_q, sum_q[bit_q]};
  assign rem_next  = (rem_shift >= {1'b0, period_q}) ?
                     PERIOD_W'(rem_shift - {1'b0, period_q}) : rem_shift[PERIOD_W-1:0];

  // Counter i uses LCG lane i mod 4.
  assign lane_sel = idx_q[1:0];
  assign lane_x   = lane_q[lane_sel];
  assign cnt_rd   = cnt_q[idx_q];

  // Shared multiplier, registered before any use of the product.
  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (rem_req_q) begin
          state_d = ST_REM;
        end else if (in_acc) begin
          if (brk && (len_q != '0)) begin
            state_d = ST_MUL;
          end else if (dump_now) begin
            state_d = ST_DUMP;
          end
        end
      end
      ST_REM: begin
        if (!rem_req_q && (bit_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        if ((mstep_q == MS_ACC_HI) && (idx_q == IDX_LAST)) begin
          state_d = dump_q ? ST_DUMP : ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (total_q == '0) begin
          state_d = ST_IDLE;
        end else if (out_free && (idx_q == IDX_LAST)) begin
          state_d = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    mstep_d   = mstep_q;
    idx_d     = idx_q;
    bit_d     = bit_q;
    rem_req_d = rem_req_q;
    dump_d    = dump_q;
    period_d  = period_q;
    phase_d   = phase_q;
    sum_d     = sum_q;
    total_d   = total_q;
    base_d    = base_q;
    len_d     = len_q;
    exp_d     = exp_q;
    closed_d  = closed_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    plen_d    = plen_q;
    lane_d    = lane_q;
    acc_d     = acc_q;
    mul_a     = '0;
    mul_b     = '0;
    ov_d      = ov_q && !dump_o.ready;
    okind_d   = okind_q;
    oidx_d    = oidx_q;
    oval_d    = oval_q;
    olast_d   = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (rem_req_q) begin
          rem_d     = '0;
          bit_d     = 6'd63;
          rem_req_d = 1'b0;
        end else if (in_acc) begin
          if (brk) begin
            total_d = total_q + len_q;
            base_d  = instr_i.fetch_address;
            len_d   = 64'd1;
            plen_d  = len_q;
            for (int j = 0; j < LANES; j++) begin
              lane_d[j] = {base_q[31:0] + 32'(j), SEED_LOW};
            end
          end else begin
            len_d = len_q + 64'd1;
          end
          exp_d    = instr_i.fetch_address + ADDR_W'(instr_i.instr_size);
          closed_d = instr_i.ends_block;
          sum_d    = sum_inc;
          phase_d  = phase_next;
          dump_d   = dump_now;
          idx_d    = '0;
          mstep_d  = MS_LO_LO;
        end
      end
      ST_REM: begin
        if (rem_req_q) begin
          rem_d     = '0;
          bit_d     = 6'd63;
          rem_req_d = 1'b0;
        end else begin
          rem_d = rem_next;
          bit_d = bit_q - 6'd1;
          if (bit_q == '0) begin
            phase_d = (period_q == '0) ? '0 : rem_next;
          end
        end
      end
      ST_MUL: begin
        unique case (mstep_q)
          MS_LO_LO: begin
            mul_a   = LCG_MUL_LO;
            mul_b   = MUL_B_W'(lane_x[HALF_W-1:0]);
            mstep_d = MS_LO_HI;
          end
          MS_LO_HI: begin
            mul_a   = LCG_MUL_LO;
            mul_b   = MUL_B_W'(lane_x[LCG_W-1:HALF_W]);
            acc_d   = prod_q[LCG_W-1:0] + LCG_ADD;
            mstep_d = MS_HI_LO;
          end
          MS_HI_LO: begin
            mul_a   = MUL_A_W'(LCG_MUL_HI);
            mul_b   = MUL_B_W'(lane_x[HALF_W-1:0]);
            acc_d   = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
            mstep_d = MS_FOLD;
          end
          MS_FOLD: begin
            lane_d[lane_sel] = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
            mstep_d          = MS_LEN_LO;
          end
          MS_LEN_LO: begin
            mul_a   = MUL_A_W'(lane_x[31:16]);
            mul_b   = plen_q[31:0];
            mstep_d = MS_LEN_HI;
          end
          MS_LEN_HI: begin
            mul_a        = MUL_A_W'(lane_x[31:16]);
            mul_b        = plen_q[63:32];
            cnt_d[idx_q] = cnt_rd + VAL_W'(prod_q[LCG_W-1:0]);
            mstep_d      = MS_ACC_HI;
          end
          MS_ACC_HI: begin
            cnt_d[idx_q] = cnt_rd + {prod_q[31:0], 32'd0};
            mstep_d      = MS_LO_LO;
            idx_d        = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
          end
          default: mstep_d = MS_LO_LO;
        endcase
      end
      ST_DUMP: begin
        if (total_q == '0) begin
          // Nothing to report, but the counters still start over.
          for (int i = 0; i < VECTOR_LEN; i++) begin
            cnt_d[i] = '0;
          end
        end else if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_COUNTER;
          oidx_d  = OUT_IDX_W'(idx_q);
          oval_d  = cnt_rd;
          olast_d = 1'b0;
          idx_d   = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
        end
      end
      ST_TOTAL: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_TOTAL;
          oidx_d  = '0;
          oval_d  = total_q;
          olast_d = 1'b1;
          for (int i = 0; i < VECTOR_LEN; i++) begin
            cnt_d[i] = '0;
          end
        end
      end
      default: ;
    endcase

    // A period write lands at once; the phase is rebuilt before the next word.
    if (cfg_we_i) begin
      period_d  = cfg_wdata_i;
      rem_req_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mstep_q   <= MS_LO_LO;
      idx_q     <= '0;
      bit_q     <= '0;
      rem_req_q <= 1'b0;
      dump_q    <= 1'b0;
      period_q  <= PERIOD_RESET;
      phase_q   <= '0;
      sum_q     <= '0;
      total_q   <= '0;
      base_q    <= '0;
      len_q     <= '0;
      exp_q     <= '0;
      closed_q  <= 1'b0;
      ov_q      <= 1'b0;
      for (int i = 0; i < VECTOR_LEN; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      mstep_q   <= mstep_d;
      idx_q     <= idx_d;
      bit_q     <= bit_d;
      rem_req_q <= rem_req_d;
      dump_q    <= dump_d;
      period_q  <= period_d;
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      total_q   <= total_d;
      base_q    <= base_d;
      len_q     <= len_d;
      exp_q     <= exp_d;
      closed_q  <= closed_d;
      ov_q      <= ov_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    plen_q  <= plen_d;
    lane_q  <= lane_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    okind_q <= okind_d;
    oidx_q  <= oidx_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  // The tracked phase is a true remainder whenever words may enter.
  `BBVP_ASSERT(a_phase_below_period, ((state_q == ST_IDLE) && !rem_req_q && (period_q != '0)) |-> (phase_q < period_q), "count phase not below dump period")

  // The multiplier loop only runs for a block that holds instructions.
  `BBVP_ASSERT(a_mul_nonempty, (state_q == ST_MUL) |-> (plen_q != '0), "projection of an empty block")

  // Once the total word is loaded the counters have been cleared.
  `BBVP_ASSERT_NEXT(a_clear_after_total, (state_q == ST_TOTAL) && out_free, (state_q == ST_IDLE) && (cnt_q[0] == '0) && dump_o.last_of_dump, "counters not cleared after dump")

endmodule
